[design/obla_pkg.sv]
// Shared types and constants of the order book level aggregator.
package obla_pkg;

    typedef enum logic [1:0] {
        CMD_NEW    = 2'd0,
        CMD_CHANGE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [1:0] SIDE_BID   = 2'd0;
    localparam logic [1:0] SIDE_OFFER = 2'd1;
    localparam logic [1:0] SIDE_TRADE = 2'd2;
    localparam logic [1:0] SIDE_ODD   = 2'd3;

    typedef enum logic [1:0] {
        NOTICE_NONE   = 2'd0,
        NOTICE_TRADE  = 2'd1,
        NOTICE_CANCEL = 2'd2
    } t_notice;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_NEW,
        OP_CHANGE,
        OP_DELETE,
        OP_CLEAR
    } t_kind;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    localparam int          TOTAL_W   = 48;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] order_key;
        logic [1:0]  side;
        logic [31:0] price;
        logic [30:0] qty;
    } t_op;

    typedef struct packed {
        logic        top_changed;
        logic [31:0] best_bid_price;
        logic [31:0] best_ask_price;
        logic [31:0] spread_ticks;
        logic [1:0]  notice;
        logic [1:0]  notice_side;
        logic [31:0] notice_price;
        logic [30:0] notice_qty;
        logic        table_full;
    } t_res;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_E_SCAN,
        BS_E_DECIDE,
        BS_E_MOV1,
        BS_E_MOV2,
        BS_L_START,
        BS_L_SCAN,
        BS_L_APPLY,
        BS_L_MOV1,
        BS_L_MOV2,
        BS_B_SCAN,
        BS_DONE
    } t_bstate;

endpackage

[design/obla_if.sv]
// Event and result channel interfaces of the order book level aggregator.
interface obla_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] order_key;
    logic [1:0]  side;
    logic [31:0] price;
    logic [30:0] qty;

    modport source (output valid, cmd, order_key, side, price, qty, input ready);
    modport sink   (input valid, cmd, order_key, side, price, qty, output ready);
endinterface

interface obla_res_if;
    logic        valid;
    logic        ready;
    logic        top_changed;
    logic [31:0] best_bid_price;
    logic [31:0] best_ask_price;
    logic [31:0] spread_ticks;
    logic [1:0]  notice;
    logic [1:0]  notice_side;
    logic [31:0] notice_price;
    logic [30:0] notice_qty;
    logic        table_full;

    modport source (output valid, top_changed, best_bid_price, best_ask_price, spread_ticks,
                    notice, notice_side, notice_price, notice_qty, table_full,
                    input ready);
    modport sink   (input valid, top_changed, best_bid_price, best_ask_price, spread_ticks,
                    notice, notice_side, notice_price, notice_qty, table_full,
                    output ready);
endinterface

[design/order_book_level_aggregator_core.sv]
// Top level of the order book level aggregator.
//
// Takes one market-by-order transaction (new, change, delete, clear) per event
// and returns one result transaction with best bid, best ask, spread, a
// top-of-book-changed flag, a trade or cancel notice and a table-full flag.
// Live entries are kept packed in the low slots of an entry memory with one
// write and one read port, and bid and ask levels packed in the low slots of a
// level memory, so a fill count stands in for per-slot valid bits and clear
// only resets the counts and best prices. A front end classifies events into
// a four-deep queue; the back engine executes one operation at a time. An
// event scans the live entries to find the id, then the live levels of the
// side for each level update (one for new or delete, up to two for change),
// rescans that side fully when its best level empties, and fills each hole a
// removal leaves with the last entry or level. Each scan reads one memory word
// per cycle through the registered read port.
module order_book_level_aggregator_core #(
    parameter int ENTRY_SLOTS = 1024,
    parameter int LEVEL_SLOTS = 256,
    parameter int PRICE_BITS  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    obla_evt_if.sink   i_evt,
    obla_res_if.source o_res
);

    // stored price width: the event carries 32 bits at most
    localparam int PRICE_W = (PRICE_BITS < 32) ? PRICE_BITS : 32;

    logic          f_valid;
    logic          f_ready;
    obla_pkg::t_op f_op;
    logic          q_valid;
    logic          q_ready;
    obla_pkg::t_op q_op;

    // classify events: fold side, mask price, turn zero-quantity new into a no-op
    obla_front #(
        .PRICE_W (PRICE_W)
    ) u_front (
        .i_evt      (i_evt),
        .o_op_valid (f_valid),
        .i_op_ready (f_ready),
        .o_op       (f_op)
    );

    // hold operations while the engine is busy
    obla_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  (f_op),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_op)
    );

    // execute against the entry and level memories
    obla_back #(
        .ENTRY_SLOTS (ENTRY_SLOTS),
        .LEVEL_SLOTS (LEVEL_SLOTS),
        .PRICE_W     (PRICE_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .o_op_ready (q_ready),
        .i_op       (q_op),
        .o_res      (o_res)
    );

endmodule

[design/obla_front.sv]
// Front end: accepts events and classifies them into operations.
module obla_front #(
    parameter int PRICE_W = 32
) (
    obla_evt_if.sink      i_evt,
    output logic          o_op_valid,
    input  logic          i_op_ready,
    output obla_pkg::t_op o_op
);

    always_comb begin
        o_op_valid     = i_evt.valid;
        i_evt.ready    = i_op_ready;
        o_op.order_key = i_evt.order_key;
        o_op.qty       = i_evt.qty;
        // fold the odd side code onto trade
        o_op.side     = (i_evt.side == obla_pkg::SIDE_ODD) ? obla_pkg::SIDE_TRADE : i_evt.side;
        // keep only the price bits the book stores
        for (int b = 0; b < 32; b++) begin
            o_op.price[b] = (b < PRICE_W) ? i_evt.price[b] : 1'b0;
        end
        unique case (obla_pkg::t_cmd'(i_evt.cmd))
            obla_pkg::CMD_NEW: begin
                o_op.kind = (i_evt.qty == 31'd0) ? obla_pkg::OP_NOP : obla_pkg::OP_NEW;
            end
            obla_pkg::CMD_CHANGE: o_op.kind = obla_pkg::OP_CHANGE;
            obla_pkg::CMD_DELETE: o_op.kind = obla_pkg::OP_DELETE;
            default:              o_op.kind = obla_pkg::OP_CLEAR;
        endcase
    end

endmodule

[design/obla_fifo.sv]
// Short operation queue between the front end and the execution engine.
module obla_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  obla_pkg::t_op i_wr_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output obla_pkg::t_op o_rd_data
);

    obla_pkg::t_op                 r_mem [obla_pkg::QDEPTH];
    logic [obla_pkg::QAW-1:0]      r_wp;
    logic [obla_pkg::QAW-1:0]      r_rp;
    logic [obla_pkg::QCW-1:0]      r_cnt;
    logic                          push;
    logic                          pop;

    assign o_wr_ready = (r_cnt != obla_pkg::QCW'(obla_pkg::QDEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + obla_pkg::QAW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + obla_pkg::QAW'(1);
            end
            r_cnt <= r_cnt + obla_pkg::QCW'(push) - obla_pkg::QCW'(pop);
        end
    end

endmodule

[design/obla_back.sv]
// Execution engine: entry table, level tables, best prices and the result register.
module obla_back #(
    parameter int ENTRY_SLOTS = 1024,
    parameter int LEVEL_SLOTS = 256,
    parameter int PRICE_W     = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    output logic          o_op_ready,
    input  obla_pkg::t_op i_op,
    obla_res_if.source    o_res
);

    localparam int EW  = $clog2(ENTRY_SLOTS);
    localparam int ECW = $clog2(ENTRY_SLOTS + 1);
    localparam int LW  = $clog2(LEVEL_SLOTS);
    localparam int LCW = $clog2(LEVEL_SLOTS + 1);
    localparam int TW  = obla_pkg::TOTAL_W;

    typedef struct packed {
        logic [63:0]        id;
        logic [1:0]         side;
        logic [PRICE_W-1:0] price;
        logic [30:0]        amt;
    } t_entry;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [TW-1:0]      total;
    } t_level;

    // memories
    t_entry r_emem [ENTRY_SLOTS];
    t_entry r_erd;
    t_level r_lmem [2**(LW+1)];
    t_level r_lrd;

    logic           e_we;
    logic [EW-1:0]  e_waddr;
    t_entry         e_wdata;
    logic [EW-1:0]  e_raddr;
    logic           l_we;
    logic [LW:0]    l_waddr;
    t_level         l_wdata;
    logic [LW:0]    l_raddr;

    obla_pkg::t_bstate r_state, n_state;
    obla_pkg::t_op     r_op, n_op;
    logic [PRICE_W-1:0] r_old_bid, n_old_bid, r_old_ask, n_old_ask;
    logic [PRICE_W-1:0] r_top_bid, n_top_bid, r_top_ask, n_top_ask;
    logic [ECW-1:0] r_ecnt, n_ecnt;
    logic [LCW-1:0] r_bcnt, n_bcnt, r_acnt, n_acnt;
    logic [ECW-1:0] r_era, n_era;
    logic           r_echk, n_echk;
    logic [EW-1:0]  r_eca, n_eca;
    logic           r_found, n_found;
    logic [EW-1:0]  r_slot, n_slot;
    t_entry         r_old, n_old;
    logic [LCW-1:0] r_lra, n_lra;
    logic           r_lchk, n_lchk;
    logic [LW-1:0]  r_lca, n_lca;
    logic           r_lfound, n_lfound;
    logic [LW-1:0]  r_lslot, n_lslot;
    logic [TW-1:0]  r_ltot, n_ltot;
    logic           r_do_rem, n_do_rem, r_do_add, n_do_add, r_ladd, n_ladd;
    logic           r_lside, n_lside;
    logic [PRICE_W-1:0] r_lprice, n_lprice;
    logic [30:0]    r_lamt, n_lamt;
    logic           r_bany, n_bany;
    logic [PRICE_W-1:0] r_bbest, n_bbest;
    obla_pkg::t_notice r_notice, n_notice;
    logic [1:0]     r_nside, n_nside;
    logic [31:0]    r_nprice, n_nprice;
    logic [30:0]    r_nqty, n_nqty;
    logic           r_full, n_full;
    logic           r_ovld, n_ovld;
    obla_pkg::t_res r_res, n_res;

    logic [LCW-1:0] lcnt_sel;
    logic [LCW-1:0] lcnt_m1;
    logic [ECW-1:0] ecnt_m1;
    logic [PRICE_W-1:0] top_sel;
    logic           e_issue;
    logic           l_issue;
    logic [TW:0]    lsum;
    logic [TW-1:0]  lsat;
    logic           store;
    logic           full_e;
    logic           better;
    logic [31:0]    bb32;
    logic [31:0]    ba32;

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_emem[e_waddr] <= e_wdata;
        end
        r_erd <= r_emem[e_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lmem[l_waddr] <= l_wdata;
        end
        r_lrd <= r_lmem[l_raddr];
    end

    assign lcnt_sel = r_lside ? r_acnt : r_bcnt;
    assign lcnt_m1  = lcnt_sel - LCW'(1);
    assign ecnt_m1  = r_ecnt - ECW'(1);
    assign top_sel  = r_lside ? r_top_ask : r_top_bid;
    assign e_issue  = (r_era < r_ecnt);
    assign l_issue  = (r_lra < lcnt_sel);
    assign lsum     = {1'b0, r_ltot} + (TW + 1)'(r_lamt);
    assign lsat     = (lsum >= {1'b0, obla_pkg::TOTAL_MAX}) ? obla_pkg::TOTAL_MAX : lsum[TW-1:0];
    assign bb32     = 32'(r_top_bid);
    assign ba32     = 32'(r_top_ask);

    assign o_res.valid          = r_ovld;
    assign o_res.top_changed    = r_res.top_changed;
    assign o_res.best_bid_price = r_res.best_bid_price;
    assign o_res.best_ask_price = r_res.best_ask_price;
    assign o_res.spread_ticks   = r_res.spread_ticks;
    assign o_res.notice         = r_res.notice;
    assign o_res.notice_side    = r_res.notice_side;
    assign o_res.notice_price   = r_res.notice_price;
    assign o_res.notice_qty     = r_res.notice_qty;
    assign o_res.table_full     = r_res.table_full;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_old_bid = r_old_bid;
        n_old_ask = r_old_ask;
        n_top_bid = r_top_bid;
        n_top_ask = r_top_ask;
        n_ecnt    = r_ecnt;
        n_bcnt    = r_bcnt;
        n_acnt    = r_acnt;
        n_era     = r_era;
        n_echk    = r_echk;
        n_eca     = r_eca;
        n_found   = r_found;
        n_slot    = r_slot;
        n_old     = r_old;
        n_lra     = r_lra;
        n_lchk    = r_lchk;
        n_lca     = r_lca;
        n_lfound  = r_lfound;
        n_lslot   = r_lslot;
        n_ltot    = r_ltot;
        n_do_rem  = r_do_rem;
        n_do_add  = r_do_add;
        n_ladd    = r_ladd;
        n_lside   = r_lside;
        n_lprice  = r_lprice;
        n_lamt    = r_lamt;
        n_bany    = r_bany;
        n_bbest   = r_bbest;
        n_notice  = r_notice;
        n_nside   = r_nside;
        n_nprice  = r_nprice;
        n_nqty    = r_nqty;
        n_full    = r_full;
        n_ovld    = r_ovld && !o_res.ready;
        n_res     = r_res;
        o_op_ready = 1'b0;
        e_we      = 1'b0;
        e_waddr   = r_slot;
        e_wdata   = r_erd;
        e_raddr   = r_era[EW-1:0];
        l_we      = 1'b0;
        l_waddr   = {r_lside, r_lslot};
        l_wdata   = r_lrd;
        l_raddr   = {r_lside, r_lra[LW-1:0]};
        store     = (r_op.kind == obla_pkg::OP_NEW)
                 || ((r_op.kind == obla_pkg::OP_CHANGE) && (r_op.qty != 31'd0));
        full_e    = store && !r_found && (r_ecnt == ECW'(ENTRY_SLOTS));
        better    = r_lside ? (r_lprice < r_top_ask) : (r_lprice > r_top_bid);

        unique case (r_state)
            obla_pkg::BS_IDLE: begin
                o_op_ready = 1'b1;
                if (i_op_valid) begin
                    n_op      = i_op;
                    n_old_bid = r_top_bid;
                    n_old_ask = r_top_ask;
                    n_notice  = obla_pkg::NOTICE_NONE;
                    n_nside   = 2'd0;
                    n_nprice  = 32'd0;
                    n_nqty    = 31'd0;
                    n_full    = 1'b0;
                    n_do_rem  = 1'b0;
                    n_do_add  = 1'b0;
                    n_era     = '0;
                    n_echk    = 1'b0;
                    unique case (i_op.kind)
                        obla_pkg::OP_CLEAR: begin
                            n_ecnt    = '0;
                            n_bcnt    = '0;
                            n_acnt    = '0;
                            n_top_bid = '0;
                            n_top_ask = '0;
                            n_state   = obla_pkg::BS_DONE;
                        end
                        obla_pkg::OP_NOP: n_state = obla_pkg::BS_DONE;
                        default:          n_state = obla_pkg::BS_E_SCAN;
                    endcase
                end
            end

            obla_pkg::BS_E_SCAN: begin
                // one read issued and one entry compared per cycle
                n_echk = e_issue;
                n_eca  = r_era[EW-1:0];
                if (e_issue) begin
                    n_era = r_era + ECW'(1);
                end
                if (r_echk && (r_erd.id == r_op.order_key)) begin
                    n_found = 1'b1;
                    n_slot  = r_eca;
                    n_old   = r_erd;
                    n_state = obla_pkg::BS_E_DECIDE;
                end else if (!r_echk && !e_issue) begin
                    n_found = 1'b0;
                    n_state = obla_pkg::BS_E_DECIDE;
                end
            end

            obla_pkg::BS_E_DECIDE: begin
                n_full   = full_e;
                n_do_rem = r_found && (r_old.side < obla_pkg::SIDE_TRADE)
                        && (r_op.kind != obla_pkg::OP_NEW);
                n_do_add = store && !full_e && (r_op.side < obla_pkg::SIDE_TRADE);
                if (store && !full_e) begin
                    e_we          = 1'b1;
                    e_waddr       = r_found ? r_slot : r_ecnt[EW-1:0];
                    e_wdata.id    = r_op.order_key;
                    e_wdata.side  = r_op.side;
                    e_wdata.price = r_op.price[PRICE_W-1:0];
                    e_wdata.amt   = r_op.qty;
                    if (!r_found) begin
                        n_ecnt = r_ecnt + ECW'(1);
                    end
                end
                if ((r_op.kind == obla_pkg::OP_NEW) && !full_e
                        && (r_op.side == obla_pkg::SIDE_TRADE)) begin
                    n_notice = obla_pkg::NOTICE_TRADE;
                    n_nside  = obla_pkg::SIDE_TRADE;
                    n_nprice = r_op.price;
                    n_nqty   = r_op.qty;
                end
                if ((r_op.kind == obla_pkg::OP_DELETE) && r_found) begin
                    n_notice = obla_pkg::NOTICE_CANCEL;
                    n_nside  = r_old.side;
                    n_nprice = 32'(r_old.price);
                    n_nqty   = r_old.amt;
                end
                n_state = (!store && r_found) ? obla_pkg::BS_E_MOV1 : obla_pkg::BS_L_START;
            end

            obla_pkg::BS_E_MOV1: begin
                // fetch the last entry to fill the hole
                e_raddr = ecnt_m1[EW-1:0];
                n_state = obla_pkg::BS_E_MOV2;
            end

            obla_pkg::BS_E_MOV2: begin
                e_we    = 1'b1;
                e_waddr = r_slot;
                e_wdata = r_erd;
                n_ecnt  = ecnt_m1;
                n_state = obla_pkg::BS_L_START;
            end

            obla_pkg::BS_L_START: begin
                n_lra  = '0;
                n_lchk = 1'b0;
                if (r_do_rem) begin
                    n_do_rem = 1'b0;
                    n_ladd   = 1'b0;
                    n_lside  = r_old.side[0];
                    n_lprice = r_old.price;
                    n_lamt   = r_old.amt;
                    n_state  = obla_pkg::BS_L_SCAN;
                end else if (r_do_add) begin
                    n_do_add = 1'b0;
                    n_ladd   = 1'b1;
                    n_lside  = r_op.side[0];
                    n_lprice = r_op.price[PRICE_W-1:0];
                    n_lamt   = r_op.qty;
                    n_state  = obla_pkg::BS_L_SCAN;
                end else begin
                    n_state = obla_pkg::BS_DONE;
                end
            end

            obla_pkg::BS_L_SCAN: begin
                n_lchk = l_issue;
                n_lca  = r_lra[LW-1:0];
                if (l_issue) begin
                    n_lra = r_lra + LCW'(1);
                end
                if (r_lchk && (r_lrd.price == r_lprice)) begin
                    n_lfound = 1'b1;
                    n_lslot  = r_lca;
                    n_ltot   = r_lrd.total;
                    n_state  = obla_pkg::BS_L_APPLY;
                end else if (!r_lchk && !l_issue) begin
                    n_lfound = 1'b0;
                    n_ltot   = '0;
                    n_state  = obla_pkg::BS_L_APPLY;
                end
            end

            obla_pkg::BS_L_APPLY: begin
                n_state = obla_pkg::BS_L_START;
                if (r_ladd) begin
                    if (r_lfound) begin
                        l_we          = 1'b1;
                        l_wdata.price = r_lprice;
                        l_wdata.total = lsat;
                    end else if (lcnt_sel == LCW'(LEVEL_SLOTS)) begin
                        n_full = 1'b1;
                    end else begin
                        l_we          = 1'b1;
                        l_waddr       = {r_lside, lcnt_sel[LW-1:0]};
                        l_wdata.price = r_lprice;
                        l_wdata.total = TW'(r_lamt);
                        if (r_lside) begin
                            n_acnt = r_acnt + LCW'(1);
                        end else begin
                            n_bcnt = r_bcnt + LCW'(1);
                        end
                        if ((lcnt_sel == '0) || better) begin
                            if (r_lside) begin
                                n_top_ask = r_lprice;
                            end else begin
                                n_top_bid = r_lprice;
                            end
                        end
                    end
                end else if (r_lfound) begin
                    if (r_ltot <= TW'(r_lamt)) begin
                        n_state = obla_pkg::BS_L_MOV1;
                    end else begin
                        l_we          = 1'b1;
                        l_wdata.price = r_lprice;
                        l_wdata.total = r_ltot - TW'(r_lamt);
                    end
                end
            end

            obla_pkg::BS_L_MOV1: begin
                l_raddr = {r_lside, lcnt_m1[LW-1:0]};
                n_state = obla_pkg::BS_L_MOV2;
            end

            obla_pkg::BS_L_MOV2: begin
                l_we    = 1'b1;
                l_wdata = r_lrd;
                if (r_lside) begin
                    n_acnt = lcnt_m1;
                end else begin
                    n_bcnt = lcnt_m1;
                end
                if (r_lprice == top_sel) begin
                    n_lra   = '0;
                    n_lchk  = 1'b0;
                    n_bany  = 1'b0;
                    n_bbest = '0;
                    n_state = obla_pkg::BS_B_SCAN;
                end else begin
                    n_state = obla_pkg::BS_L_START;
                end
            end

            obla_pkg::BS_B_SCAN: begin
                // best price went away: rescan the side
                n_lchk = l_issue;
                if (l_issue) begin
                    n_lra = r_lra + LCW'(1);
                end
                if (r_lchk) begin
                    n_bany = 1'b1;
                    if (!r_bany || (r_lside ? (r_lrd.price < r_bbest)
                                            : (r_lrd.price > r_bbest))) begin
                        n_bbest = r_lrd.price;
                    end
                end else if (!l_issue) begin
                    if (r_lside) begin
                        n_top_ask = r_bany ? r_bbest : '0;
                    end else begin
                        n_top_bid = r_bany ? r_bbest : '0;
                    end
                    n_state = obla_pkg::BS_L_START;
                end
            end

            obla_pkg::BS_DONE: begin
                if (!r_ovld || o_res.ready) begin
                    n_ovld               = 1'b1;
                    n_res.top_changed    = (r_top_bid != r_old_bid) || (r_top_ask != r_old_ask);
                    n_res.best_bid_price = bb32;
                    n_res.best_ask_price = ba32;
                    n_res.spread_ticks   = ((bb32 != 32'd0) && (ba32 != 32'd0) && (ba32 >= bb32))
                                         ? (ba32 - bb32) : 32'd0;
                    n_res.notice         = r_notice;
                    n_res.notice_side    = r_nside;
                    n_res.notice_price   = r_nprice;
                    n_res.notice_qty     = r_nqty;
                    n_res.table_full     = r_full;
                    n_state              = obla_pkg::BS_IDLE;
                end
            end

            default: n_state = obla_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= obla_pkg::BS_IDLE;
            r_top_bid <= '0;
            r_top_ask <= '0;
            r_ecnt    <= '0;
            r_bcnt    <= '0;
            r_acnt    <= '0;
            r_ovld    <= 1'b0;
            r_do_rem  <= 1'b0;
            r_do_add  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top_bid <= n_top_bid;
            r_top_ask <= n_top_ask;
            r_ecnt    <= n_ecnt;
            r_bcnt    <= n_bcnt;
            r_acnt    <= n_acnt;
            r_ovld    <= n_ovld;
            r_do_rem  <= n_do_rem;
            r_do_add  <= n_do_add;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_old_bid <= n_old_bid;
        r_old_ask <= n_old_ask;
        r_era     <= n_era;
        r_echk    <= n_echk;
        r_eca     <= n_eca;
        r_found   <= n_found;
        r_slot    <= n_slot;
        r_old     <= n_old;
        r_lra     <= n_lra;
        r_lchk    <= n_lchk;
        r_lca     <= n_lca;
        r_lfound  <= n_lfound;
        r_lslot   <= n_lslot;
        r_ltot    <= n_ltot;
        r_ladd    <= n_ladd;
        r_lside   <= n_lside;
        r_lprice  <= n_lprice;
        r_lamt    <= n_lamt;
        r_bany    <= n_bany;
        r_bbest   <= n_bbest;
        r_notice  <= n_notice;
        r_nside   <= n_nside;
        r_nprice  <= n_nprice;
        r_nqty    <= n_nqty;
        r_full    <= n_full;
        r_res     <= n_res;
    end

endmodule
